// ===== rtl/ifse_pkg.sv =====
// Shared types and constants of the information frame stuffing encoder.
// Used by the front end, item queue, back end and top level; depends on nothing.
package ifse_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FLAG      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_SUB  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_SUB   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INFO_ADDR = 3'd4;

  // Register values after reset.
  localparam logic [BYTE_W-1:0] RST_FLAG      = 8'd126;
  localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'd125;
  localparam logic [BYTE_W-1:0] RST_FLAG_SUB  = 8'd94;
  localparam logic [BYTE_W-1:0] RST_ESC_SUB   = 8'd93;
  localparam logic [BYTE_W-1:0] RST_INFO_ADDR = 8'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] flag;
    logic [BYTE_W-1:0] escape;
    logic [BYTE_W-1:0] flag_sub;
    logic [BYTE_W-1:0] esc_sub;
    logic [BYTE_W-1:0] info_addr;
  } cfg_t;

  // One classified item as handed from the front end to the back end.
  typedef struct packed {
    logic              sup;     // supervision frame
    logic              hdr;     // emit the four header bytes first
    logic              last;    // close the information frame after the data
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] ctrl;
    logic [BYTE_W-1:0] addr;    // resolved header address
    logic [BYTE_W-1:0] par;     // parity byte including this item's data
  } cmd_t;

endpackage

// ===== rtl/ifse_in_if.sv =====
// Input channel of the frame encoder: valid/ready handshake and item fields.
// Depends on nothing.
interface ifse_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic [7:0] control;
  logic [7:0] address;
  logic       last_byte;

  modport source (output valid, mode, data_byte, control, address, last_byte,
                  input ready);
  modport sink (input valid, mode, data_byte, control, address, last_byte,
                output ready);
endinterface

// ===== rtl/ifse_out_if.sv =====
// Result channel of the frame encoder: valid/ready handshake and line byte fields.
// Depends on nothing.
interface ifse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       last_out;

  modport source (output valid, out_byte, frame_end, last_out, input ready);
  modport sink (input valid, out_byte, frame_end, last_out, output ready);
endinterface

// ===== rtl/ifse_front.sv =====
// Front end: accepts items, tracks the open frame and its running parity,
// and pushes one classified command per item. Depends on ifse_pkg.
module ifse_front
  import ifse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [BYTE_W-1:0] in_control,
  input  logic [BYTE_W-1:0] in_address,
  input  logic              in_last_byte,
  input  cfg_t              cfg,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic              in_frame_r, in_frame_nxt;
  logic [BYTE_W-1:0] parity_r, parity_nxt;
  logic [BYTE_W-1:0] par_acc;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // A frame's first byte starts the parity from zero.
  assign par_acc = (in_frame_r ? parity_r : '0) ^ in_data_byte;

  always_comb begin
    q_cmd.sup  = in_mode;
    q_cmd.hdr  = in_mode || !in_frame_r;
    q_cmd.last = in_last_byte;
    q_cmd.data = in_data_byte;
    q_cmd.ctrl = in_control;
    q_cmd.addr = in_mode ? in_address : cfg.info_addr;
    q_cmd.par  = par_acc;

    in_frame_nxt = in_frame_r;
    parity_nxt   = parity_r;
    if (q_push) begin
      if (in_mode || in_last_byte) begin
        in_frame_nxt = 1'b0;
        parity_nxt   = '0;
      end else begin
        in_frame_nxt = 1'b1;
        parity_nxt   = par_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      parity_r   <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      parity_r   <= parity_nxt;
    end
  end

endmodule

// ===== rtl/ifse_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on ifse_pkg for the command type.
module ifse_queue
  import ifse_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t            mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;

  assign full      = (count_r == (AW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/ifse_back.sv =====
// Back end: walks the queue head through header, stuffed data, stuffed parity
// and closing flag, one line byte per cycle unless stalled. Depends on ifse_pkg.
module ifse_back
  import ifse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              q_not_empty,
  input  cmd_t              q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_frame_end,
  output logic              out_last
);

  localparam logic [2:0] ST_START = 3'd0;
  localparam logic [2:0] ST_HFLAG = 3'd1;
  localparam logic [2:0] ST_HADDR = 3'd2;
  localparam logic [2:0] ST_HCTRL = 3'd3;
  localparam logic [2:0] ST_HCHK  = 3'd4;
  localparam logic [2:0] ST_DATA  = 3'd5;
  localparam logic [2:0] ST_PAR   = 3'd6;
  localparam logic [2:0] ST_CLOSE = 3'd7;

  logic [2:0]        step_r, step_nxt;
  logic              sub_r, sub_nxt;
  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              end_r, end_nxt;
  logic              last_r, last_nxt;

  logic [2:0]        cur;
  logic [BYTE_W-1:0] src;
  logic              is_flag, is_esc;
  logic              advance, done;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_end;

  assign cur     = (step_r == ST_START) ? (q_head.hdr ? ST_HFLAG : ST_DATA) : step_r;
  assign src     = (cur == ST_PAR) ? q_head.par : q_head.data;
  assign is_flag = (src == cfg.flag);
  assign is_esc  = (src == cfg.escape);
  assign advance = q_not_empty && (!valid_r || out_ready);

  always_comb begin
    emit_byte = cfg.flag;
    emit_end  = 1'b0;
    done      = 1'b0;
    step_nxt  = step_r;
    sub_nxt   = 1'b0;
    case (cur)
      ST_HFLAG: begin
        step_nxt = ST_HADDR;
      end
      ST_HADDR: begin
        emit_byte = q_head.addr;
        step_nxt  = ST_HCTRL;
      end
      ST_HCTRL: begin
        emit_byte = q_head.ctrl;
        step_nxt  = ST_HCHK;
      end
      ST_HCHK: begin
        emit_byte = q_head.addr ^ q_head.ctrl;
        step_nxt  = q_head.sup ? ST_CLOSE : ST_DATA;
      end
      ST_DATA, ST_PAR: begin
        if ((is_flag || is_esc) && !sub_r) begin
          // First half of a stuffed byte: the escape.
          emit_byte = cfg.escape;
          sub_nxt   = 1'b1;
          step_nxt  = cur;
        end else begin
          if (!sub_r) begin
            emit_byte = src;
          end else if (is_flag) begin
            emit_byte = cfg.flag_sub;
          end else begin
            emit_byte = cfg.esc_sub;
          end
          if (cur == ST_PAR) begin
            step_nxt = ST_CLOSE;
          end else if (q_head.last) begin
            step_nxt = ST_PAR;
          end else begin
            done = 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        emit_end = 1'b1;
        done     = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    if (done) begin
      step_nxt = ST_START;
    end
  end

  assign q_pop = advance && done;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    end_nxt   = end_r;
    last_nxt  = last_r;
    if (advance) begin
      valid_nxt = 1'b1;
      byte_nxt  = emit_byte;
      end_nxt   = emit_end;
      last_nxt  = done;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_START;
      sub_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (advance) begin
        step_r <= step_nxt;
        sub_r  <= sub_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_frame_end = end_r;
  assign out_last      = last_r;

endmodule

// ===== rtl/info_frame_stuffing_encoder.sv =====
// Top level of the information frame stuffing encoder: configuration registers,
// front end, command queue and back end. Depends on ifse_pkg and the channel interfaces.
//
//   port       direction  handshake        carries
//   in_chan    sink       valid / ready    mode, data_byte, control, address, last_byte
//   out_chan   source     valid / ready    out_byte, frame_end, last_out
//   cfg_*      write      cfg_we           cfg_index, cfg_wdata
//
// The back end sends one line byte per cycle while the result channel takes them;
// an item has as many result bytes as it needs: 1 or 2 for a payload byte, 4 more
// with a header, 2 to 3 more when it closes a frame, and 5 for a supervision frame.
// The front end accepts an item every cycle while the command queue has room.
// Reset is synchronous; there is no clearing pass.
// A stalled result channel holds the output register and the queue fills behind it.
module info_frame_stuffing_encoder
  import ifse_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ifse_in_if.sink              in_chan,
  ifse_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_push, q_pop, q_not_empty;
  cmd_t q_cmd, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FLAG:      cfg_nxt.flag      = cfg_wdata;
        REG_ESCAPE:    cfg_nxt.escape    = cfg_wdata;
        REG_FLAG_SUB:  cfg_nxt.flag_sub  = cfg_wdata;
        REG_ESC_SUB:   cfg_nxt.esc_sub   = cfg_wdata;
        REG_INFO_ADDR: cfg_nxt.info_addr = cfg_wdata;
        default:       cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag      <= RST_FLAG;
      cfg_r.escape    <= RST_ESCAPE;
      cfg_r.flag_sub  <= RST_FLAG_SUB;
      cfg_r.esc_sub   <= RST_ESC_SUB;
      cfg_r.info_addr <= RST_INFO_ADDR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ifse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_mode      (in_chan.mode),
    .in_data_byte (in_chan.data_byte),
    .in_control   (in_chan.control),
    .in_address   (in_chan.address),
    .in_last_byte (in_chan.last_byte),
    .cfg          (cfg_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  ifse_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  ifse_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_byte      (out_chan.out_byte),
    .out_frame_end (out_chan.frame_end),
    .out_last      (out_chan.last_out)
  );

endmodule

// ===== rtl/ifse_checker.sv =====
// Port-level checks of the frame encoder's result channel, bound to the top level.
// Depends on the top level's port list only.
module ifse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_frame_end,
  input logic       out_last
);

  // A result that has not been taken stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_frame_end)
                                && $stable(out_last))
    else $error("stalled result changed");

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // The closing flag is always the final result of its item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_last)
    else $error("closing flag not marked as the item's last result");

endmodule

bind info_frame_stuffing_encoder ifse_checker u_ifse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_byte      (out_chan.out_byte),
  .out_frame_end (out_chan.frame_end),
  .out_last      (out_chan.last_out)
);
